// ===== rtl/fqs_pkg.sv =====
package fqs_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;
  localparam int SUM_W     = 36;
  localparam int CNT_W     = 5;
  localparam int FUNC_W    = 2;
  localparam int ST_W      = 2;

  localparam logic [FUNC_W-1:0] FN_ENQ   = 2'd0;
  localparam logic [FUNC_W-1:0] FN_DEQ   = 2'd1;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;
  localparam logic [FUNC_W-1:0] FN_QUERY = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic valid;
    logic first;
  } scan_ctl_t;

endpackage

// ===== rtl/fqs_ram.sv =====
module fqs_ram #(
  parameter int DEPTH = fqs_pkg::DEPTH_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [fqs_pkg::VAL_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [fqs_pkg::VAL_W-1:0] rdata
);
  import fqs_pkg::*;

  logic [VAL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fqs_scan.sv =====
module fqs_scan (
  input  logic                             clk,
  input  fqs_pkg::scan_ctl_t               ctl,
  input  logic signed [fqs_pkg::VAL_W-1:0] data,
  output logic signed [fqs_pkg::VAL_W-1:0] head,
  output logic signed [fqs_pkg::VAL_W-1:0] tail,
  output logic signed [fqs_pkg::VAL_W-1:0] largest,
  output logic signed [fqs_pkg::VAL_W-1:0] smallest
);
  import fqs_pkg::*;

  // one shared comparator pair, one word per cycle
  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      tail <= data;
      if (ctl.first) begin
        head     <= data;
        largest  <= data;
        smallest <= data;
      end else begin
        if (data > largest) begin
          largest <= data;
        end
        if (data < smallest) begin
          smallest <= data;
        end
      end
    end
  end

endmodule

// ===== rtl/fifo_queue_with_stats_unit.sv =====
// fifo_queue_with_stats_unit: bounded fifo of signed 32-bit words with statistics
// channels: a command is taken on a rising edge with start high and busy low;
//   func selects enqueue, dequeue, clear or query, value_in is the word to enqueue
// every command gives one result, shown for exactly one cycle with done high:
//   status, removed word, head, tail, count, total, largest and smallest
// steps: the command is registered, the operation is applied (a successful dequeue
//   takes an extra state to read the head word), the stored words are walked unless
//   the queue is empty after the operation, and the result registers are loaded
// the walk uses one memory read port and one comparator pair, one word per cycle
// throughput: one command at a time, busy stays high until the result is out;
//   a new command may be taken in the cycle that done is high
// reset (rst, synchronous): queue empties, pointers and sum return to zero;
//   stored words are not cleared and are never read before written
// the receiver cannot stall: results must be taken in the cycle done is high
module fifo_queue_with_stats_unit #(
  parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [fqs_pkg::FUNC_W-1:0]        func,
  input  logic signed [fqs_pkg::VAL_W-1:0]  value_in,
  output logic                              done,
  output logic [fqs_pkg::ST_W-1:0]          status,
  output logic signed [fqs_pkg::VAL_W-1:0]  removed_value,
  output logic signed [fqs_pkg::VAL_W-1:0]  head_value,
  output logic signed [fqs_pkg::VAL_W-1:0]  tail_value,
  output logic [fqs_pkg::CNT_W-1:0]         count,
  output logic signed [fqs_pkg::SUM_W-1:0]  total,
  output logic signed [fqs_pkg::VAL_W-1:0]  largest,
  output logic signed [fqs_pkg::VAL_W-1:0]  smallest
);
  import fqs_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OP   = 3'd1;
  localparam logic [2:0] S_DEQ  = 3'd2;
  localparam logic [2:0] S_PREP = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]              state;
  logic [FUNC_W-1:0]       op_func;
  logic [VAL_W-1:0]        op_value;
  logic [ST_W-1:0]         op_status;
  logic [VAL_W-1:0]        removed;
  logic [AW-1:0]           rd;
  logic [AW-1:0]           wr;
  logic [CW-1:0]           fill;
  logic [SUM_W-1:0]        sum;
  logic [AW-1:0]           saddr;
  logic [CW-1:0]           issued;
  logic                    rvalid;
  logic                    sfirst;

  logic                    mem_we;
  logic [AW-1:0]           mem_raddr;
  logic [VAL_W-1:0]        mem_rdata;
  logic                    issue;
  scan_ctl_t               sctl;
  logic signed [VAL_W-1:0] s_head;
  logic signed [VAL_W-1:0] s_tail;
  logic signed [VAL_W-1:0] s_max;
  logic signed [VAL_W-1:0] s_min;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
    return (idx == LAST_IDX) ? '0 : idx + AW'(1);
  endfunction

  assign busy      = (state != S_IDLE);
  assign mem_we    = (state == S_OP) && (op_func == FN_ENQ) && (fill != FULL_CNT);
  assign mem_raddr = (state == S_OP) ? rd : saddr;
  assign issue     = (state == S_SCAN) && (issued < fill);
  assign sctl      = '{valid: rvalid, first: sfirst};

  fqs_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr),
    .wdata (op_value),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fqs_scan u_scan (
    .clk      (clk),
    .ctl      (sctl),
    .data     (mem_rdata),
    .head     (s_head),
    .tail     (s_tail),
    .largest  (s_max),
    .smallest (s_min)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd     <= '0;
      wr     <= '0;
      fill   <= '0;
      sum    <= '0;
      rvalid <= 1'b0;
      done   <= 1'b0;
    end else begin
      done   <= 1'b0;
      rvalid <= issue;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_func   <= func;
            op_value  <= value_in;
            op_status <= ST_OK;
            removed   <= '0;
            state     <= S_OP;
          end
        end
        S_OP: begin
          state <= S_PREP;
          case (op_func)
            FN_ENQ: begin
              if (fill == FULL_CNT) begin
                op_status <= ST_FULL;
              end else begin
                wr   <= wrap_inc(wr);
                fill <= fill + CW'(1);
                sum  <= sum + {{(SUM_W - VAL_W){op_value[VAL_W-1]}}, op_value};
              end
            end
            FN_DEQ: begin
              if (fill == '0) begin
                op_status <= ST_EMPTY;
              end else begin
                state <= S_DEQ;
              end
            end
            FN_CLEAR: begin
              if (fill == '0) begin
                op_status <= ST_EMPTY;
              end else begin
                rd   <= '0;
                wr   <= '0;
                fill <= '0;
                sum  <= '0;
              end
            end
            default: begin
              if (fill == '0) begin
                op_status <= ST_EMPTY;
              end
            end
          endcase
        end
        S_DEQ: begin
          removed <= mem_rdata;
          rd      <= wrap_inc(rd);
          fill    <= fill - CW'(1);
          sum     <= sum - {{(SUM_W - VAL_W){mem_rdata[VAL_W-1]}}, mem_rdata};
          state   <= S_PREP;
        end
        S_PREP: begin
          saddr  <= rd;
          issued <= '0;
          sfirst <= 1'b1;
          state  <= (fill == '0) ? S_FIN : S_SCAN;
        end
        S_SCAN: begin
          if (issue) begin
            saddr  <= wrap_inc(saddr);
            issued <= issued + CW'(1);
          end
          if (rvalid) begin
            sfirst <= 1'b0;
            if (issued == fill) begin
              state <= S_FIN;
            end
          end
        end
        S_FIN: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state == S_FIN) begin
      status        <= op_status;
      removed_value <= removed;
      count         <= CNT_W'(fill);
      if (fill == '0) begin
        head_value <= '0;
        tail_value <= '0;
        total      <= '0;
        largest    <= '0;
        smallest   <= '0;
      end else begin
        head_value <= s_head;
        tail_value <= s_tail;
        total      <= sum;
        largest    <= s_max;
        smallest   <= s_min;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FULL_CNT)
    else $error("fill count beyond depth");

  a_done_from_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_FIN))
    else $error("done without finishing a command");

  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command taken but block not busy");

  a_empty_stats: assert property (@(posedge clk) disable iff (rst)
    (done && (count == '0) && (DEPTH < 32)) |-> (total == '0 && largest == '0))
    else $error("statistics not zero on empty queue");

endmodule
